// ----- rtl/vha_pkg.sv -----
// shared types and constants of the versioned handle allocator
// no dependencies
`default_nettype none

package vha_pkg;

   // pool geometry
   localparam int POOL_SLOTS   = 1024;
   localparam int VERSION_BITS = 16;

   // port field widths
   localparam int CMD_W     = 2;
   localparam int IDX_W     = $clog2(POOL_SLOTS);
   localparam int VER_W     = VERSION_BITS;
   localparam int CNT_OUT_W = $clog2(POOL_SLOTS + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_MARK    = 2'd1,
      CMD_CLEANUP = 2'd2,
      CMD_CHECK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_POOL_FULL = 2'd1,
      ST_MARK_FULL = 2'd2,
      ST_INVALID   = 2'd3
   } status_type;

   // one decoded request word
   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] index;
      logic [VER_W-1:0] version;
   } item_type;

endpackage

`default_nettype wire

// ----- rtl/vha_req_if.sv -----
// request channel: valid/ready with command, index and version
// depends on vha_pkg
`default_nettype none

interface vha_req_if;
   logic                      valid;
   logic                      ready;
   logic [vha_pkg::CMD_W-1:0] cmd;
   logic [vha_pkg::IDX_W-1:0] entity_index;
   logic [vha_pkg::VER_W-1:0] entity_version;

   modport source (output valid, cmd, entity_index, entity_version, input ready);
   modport sink   (input valid, cmd, entity_index, entity_version, output ready);
endinterface

`default_nettype wire

// ----- rtl/vha_rsp_if.sv -----
// response channel: valid/ready with status, handle and counters
// depends on vha_pkg
`default_nettype none

interface vha_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [vha_pkg::IDX_W-1:0]     out_index;
   logic [vha_pkg::VER_W-1:0]     out_version;
   logic                          is_valid;
   logic [vha_pkg::CNT_OUT_W-1:0] alive_count;
   logic [vha_pkg::CNT_OUT_W-1:0] free_count;
   logic [vha_pkg::CNT_OUT_W-1:0] pool_size;

   modport source (output valid, status, out_index, out_version, is_valid,
                   alive_count, free_count, pool_size, input ready);
   modport sink   (input valid, status, out_index, out_version, is_valid,
                   alive_count, free_count, pool_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/vha_front.sv -----
// front end: accepts request words, decodes the command, two-entry queue
// depends on vha_pkg, vha_req_if
`default_nettype none

module vha_front (
   input  wire              clock,
   input  wire              reset,
   vha_req_if.sink          req,
   output logic             q_valid,
   input  wire              q_ready,
   output vha_pkg::item_type q_item
);

   vha_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   vha_pkg::item_type decoded;

   // decode incoming word
   always_comb begin
      decoded.cmd     = vha_pkg::cmd_type'(req.cmd);
      decoded.index   = req.entity_index;
      decoded.version = req.entity_version;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_item    = entry_ff[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vha_back.sv -----
// back end: slot, free stack and mark queue memories with a command sequencer
// depends on vha_pkg, vha_rsp_if
`default_nettype none

module vha_back #(
   parameter int MARK_DEPTH   = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               q_valid,
   output logic              q_ready,
   input  vha_pkg::item_type q_item,
   vha_rsp_if.source         rsp
);

   localparam int POOL_SLOTS = vha_pkg::POOL_SLOTS;
   localparam int IW    = vha_pkg::IDX_W;
   localparam int VW    = vha_pkg::VER_W;
   localparam int OW    = vha_pkg::CNT_OUT_W;
   localparam int SA_W  = $clog2(POOL_SLOTS);
   localparam int CNT_W = $clog2(POOL_SLOTS + 1);
   localparam int MA_W  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
   localparam int MC_W  = $clog2(MARK_DEPTH + 1);
   localparam int CMP_W = (IW > CNT_W) ? IW : CNT_W;
   localparam int VB    = vha_pkg::VERSION_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_CR_FS_W, S_CR_FS, S_CR_SL_W, S_CR_SL,
      S_CL_MK_W, S_CL_MK, S_CL_SL_W, S_CL_SL, S_CK_W, S_CK
   } state_type;

   state_type state_ff;

   // memories: slot word is {live, version}; mark word is {index, version}
   logic [VB:0]      slot_mem [POOL_SLOTS];
   logic [SA_W-1:0]  fs_mem   [POOL_SLOTS];
   logic [IW+VB-1:0] mk_mem   [MARK_DEPTH];

   logic             slot_we_ff, fs_we_ff, mk_we_ff;
   logic [SA_W-1:0]  slot_wa_ff, fs_wa_ff, slot_ra_ff, fs_ra_ff;
   logic [MA_W-1:0]  mk_wa_ff, mk_ra_ff;
   logic [VB:0]      slot_wd_ff, slot_q_ff;
   logic [SA_W-1:0]  fs_wd_ff, fs_q_ff;
   logic [IW+VB-1:0] mk_wd_ff, mk_q_ff;

   // counters and work registers
   logic [CNT_W-1:0] used_ff, free_ff;
   logic [MC_W-1:0]  mcount_ff, k_ff;
   logic [SA_W-1:0]  cur_idx_ff;
   logic [VB-1:0]    cur_ver_ff;

   // response register
   logic             rsp_valid_ff;
   logic [1:0]       status_ff;
   logic [IW-1:0]    out_index_ff;
   logic [VW-1:0]    out_version_ff;
   logic             is_valid_ff;

   logic             start, last, mk_in_range, cl_hit, ck_in_range;
   logic [VB-1:0]    req_ver;
   logic [IW-1:0]    mk_idx;
   logic [VB-1:0]    mk_ver;

   always_ff @(posedge clock) begin
      if (slot_we_ff) slot_mem[slot_wa_ff] <= slot_wd_ff;
      slot_q_ff <= slot_mem[slot_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (fs_we_ff) fs_mem[fs_wa_ff] <= fs_wd_ff;
      fs_q_ff <= fs_mem[fs_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (mk_we_ff) mk_mem[mk_wa_ff] <= mk_wd_ff;
      mk_q_ff <= mk_mem[mk_ra_ff];
   end

   // decode helpers
   assign q_ready     = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign start       = q_valid && q_ready;
   assign req_ver     = VB'(q_item.version);
   assign mk_idx      = mk_q_ff[IW+VB-1:VB];
   assign mk_ver      = mk_q_ff[VB-1:0];
   assign mk_in_range = CMP_W'(mk_idx) < CMP_W'(used_ff);
   assign ck_in_range = CMP_W'(q_item.index) < CMP_W'(used_ff);
   assign last        = (k_ff + MC_W'(1)) == mcount_ff;
   assign cl_hit      = slot_q_ff[VB] && (slot_q_ff[VB-1:0] == cur_ver_ff)
                        && (free_ff < CNT_W'(POOL_SLOTS));

   // outputs
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.out_index   = out_index_ff;
   assign rsp.out_version = out_version_ff;
   assign rsp.is_valid    = is_valid_ff;
   assign rsp.alive_count = OW'(used_ff - free_ff);
   assign rsp.free_count  = OW'(free_ff);
   assign rsp.pool_size   = OW'(used_ff);

   // command sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         free_ff      <= '0;
         mcount_ff    <= '0;
         slot_we_ff   <= 1'b0;
         fs_we_ff     <= 1'b0;
         mk_we_ff     <= 1'b0;
      end else begin
         slot_we_ff <= 1'b0;
         fs_we_ff   <= 1'b0;
         mk_we_ff   <= 1'b0;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  status_ff      <= vha_pkg::ST_OK;
                  out_index_ff   <= '0;
                  out_version_ff <= '0;
                  is_valid_ff    <= 1'b0;
                  unique case (q_item.cmd)
                     vha_pkg::CMD_CREATE: begin
                        if (free_ff != '0) begin
                           fs_ra_ff <= SA_W'(free_ff - CNT_W'(1));
                           free_ff  <= free_ff - CNT_W'(1);
                           state_ff <= S_CR_FS_W;
                        end else if (used_ff < CNT_W'(POOL_SLOTS)) begin
                           slot_we_ff   <= 1'b1;
                           slot_wa_ff   <= SA_W'(used_ff);
                           slot_wd_ff   <= {1'b1, {VB{1'b0}}};
                           used_ff      <= used_ff + CNT_W'(1);
                           out_index_ff <= IW'(used_ff);
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           status_ff    <= vha_pkg::ST_POOL_FULL;
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     vha_pkg::CMD_MARK: begin
                        if (mcount_ff < MC_W'(MARK_DEPTH)) begin
                           mk_we_ff  <= 1'b1;
                           mk_wa_ff  <= MA_W'(mcount_ff);
                           mk_wd_ff  <= {q_item.index, req_ver};
                           mcount_ff <= mcount_ff + MC_W'(1);
                        end else begin
                           status_ff <= vha_pkg::ST_MARK_FULL;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     vha_pkg::CMD_CLEANUP: begin
                        if (mcount_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           k_ff     <= '0;
                           mk_ra_ff <= '0;
                           state_ff <= S_CL_MK_W;
                        end
                     end
                     vha_pkg::CMD_CHECK: begin
                        if (ck_in_range) begin
                           slot_ra_ff <= SA_W'(q_item.index);
                           cur_ver_ff <= req_ver;
                           state_ff   <= S_CK_W;
                        end else begin
                           status_ff    <= vha_pkg::ST_INVALID;
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_CR_FS_W: state_ff <= S_CR_FS;
            S_CR_FS: begin
               slot_ra_ff <= fs_q_ff;
               cur_idx_ff <= fs_q_ff;
               state_ff   <= S_CR_SL_W;
            end
            S_CR_SL_W: state_ff <= S_CR_SL;
            S_CR_SL: begin
               // reuse freed slot at its stored version
               slot_we_ff     <= 1'b1;
               slot_wa_ff     <= cur_idx_ff;
               slot_wd_ff     <= {1'b1, slot_q_ff[VB-1:0]};
               out_index_ff   <= IW'(cur_idx_ff);
               out_version_ff <= VW'(slot_q_ff[VB-1:0]);
               rsp_valid_ff   <= 1'b1;
               state_ff       <= S_IDLE;
            end
            S_CL_MK_W: state_ff <= S_CL_MK;
            S_CL_MK, S_CL_SL: begin
               // look up the marked slot, or free a matching slot and go to the next mark or finish
               if (state_ff == S_CL_MK && mk_in_range) begin
                  slot_ra_ff <= SA_W'(mk_idx);
                  cur_idx_ff <= SA_W'(mk_idx);
                  cur_ver_ff <= mk_ver;
                  state_ff   <= S_CL_SL_W;
               end else begin
                  if (state_ff == S_CL_SL && cl_hit) begin
                     slot_we_ff <= 1'b1;
                     slot_wa_ff <= cur_idx_ff;
                     slot_wd_ff <= {1'b0, slot_q_ff[VB-1:0] + VB'(1)};
                     fs_we_ff   <= 1'b1;
                     fs_wa_ff   <= SA_W'(free_ff);
                     fs_wd_ff   <= cur_idx_ff;
                     free_ff    <= free_ff + CNT_W'(1);
                  end
                  if (last) begin
                     mcount_ff    <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + MC_W'(1);
                     mk_ra_ff <= MA_W'(k_ff + MC_W'(1));
                     state_ff <= S_CL_MK_W;
                  end
               end
            end
            S_CL_SL_W: state_ff <= S_CL_SL;
            S_CK_W: state_ff <= S_CK;
            S_CK: begin
               if (slot_q_ff[VB] && (slot_q_ff[VB-1:0] == cur_ver_ff)) begin
                  is_valid_ff <= 1'b1;
               end else begin
                  status_ff <= vha_pkg::ST_INVALID;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/versioned_handle_allocator.sv -----
// top level of the versioned handle allocator
// depends on vha_pkg, vha_req_if, vha_rsp_if, vha_front, vha_back
//
// channel   dir  word
// req_port  in   cmd, entity_index, entity_version
// rsp_port  out  status, out_index, out_version, is_valid, alive/free counts, pool_size
//
// mark, new-slot create, full or empty-queue answers: straight from the idle state;
// in-range check: a slot memory read; create from the free stack: a free stack read,
// then a slot read; cleanup: a mark read per queued mark, plus a slot read if in range;
// a two-entry queue takes words while the sequencer works; the sequencer waits
// only while an earlier response is held; synchronous reset clears pool, free, mark counts
`default_nettype none

module versioned_handle_allocator #(
   parameter int MARK_DEPTH   = 64
) (
   input wire         clock,
   input wire         reset,
   vha_req_if.sink    req_port,
   vha_rsp_if.source  rsp_port
);

   logic              q_valid, q_ready;
   vha_pkg::item_type q_item;

   vha_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_port),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   vha_back #(
      .MARK_DEPTH   (MARK_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item),
      .rsp     (rsp_port)
   );

endmodule

`default_nettype wire

// ----- tb/sv/versioned_handle_allocator_tb.sv -----
// self-checking testbench for the versioned handle allocator
// depends on vha_pkg, vha_req_if, vha_rsp_if and versioned_handle_allocator
`timescale 1ns / 1ps

module versioned_handle_allocator_tb;

   localparam int SLOTS    = vha_pkg::POOL_SLOTS;
   localparam int QDEPTH   = 64;
   localparam int SETTLE   = 300;
   localparam int IW       = vha_pkg::IDX_W;
   localparam int VW       = vha_pkg::VER_W;
   localparam int OW       = vha_pkg::CNT_OUT_W;

   typedef struct packed {
      vha_pkg::status_type status;
      logic [IW-1:0]       index;
      logic [VW-1:0]       version;
      logic                valid;
      logic [OW-1:0]       alive;
      logic [OW-1:0]       free;
      logic [OW-1:0]       pool;
   } answer_type;

   typedef struct {
      vha_pkg::cmd_type cmd;
      logic [IW-1:0]    index;
      logic [VW-1:0]    version;
      bit               typed;
      answer_type       answer;
   } row_type;

   logic clock = 0;
   logic reset = 1;

   vha_req_if req_port ();
   vha_rsp_if rsp_port ();

   versioned_handle_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source)
   );

   always #5 clock = ~clock;

   // shadow state of the allocator
   logic [VW-1:0] shadow_ver [SLOTS];
   bit            shadow_live [SLOTS];
   logic [IW-1:0] shadow_free [SLOTS];
   logic [IW-1:0] pend_idx [QDEPTH];
   logic [VW-1:0] pend_ver [QDEPTH];
   int            slots_used, free_top, pend_count;

   answer_type    pending_answers [$];
   logic [25:0]   known_handles [$];
   row_type       script [$];

   int  mismatches, answers_seen, words_sent, mark_full_seen, invalid_seen;
   bit  hold_off, pressure_go;
   int  burst_left;

   // next state and answer for one accepted word
   function automatic answer_type allocate_step(vha_pkg::cmd_type c, logic [IW-1:0] idx,
                                                logic [VW-1:0] ver);
      answer_type a;
      int s;
      a = '0;
      a.status = vha_pkg::ST_OK;
      case (c)
         vha_pkg::CMD_CREATE: begin
            if (free_top > 0) begin
               free_top--;
               s = int'(shadow_free[free_top]);
               shadow_live[s] = 1;
               a.index = IW'(s);
               a.version = shadow_ver[s];
            end else if (slots_used < SLOTS) begin
               s = slots_used;
               shadow_ver[s] = '0;
               shadow_live[s] = 1;
               slots_used++;
               a.index = IW'(s);
            end else begin
               a.status = vha_pkg::ST_POOL_FULL;
            end
         end
         vha_pkg::CMD_MARK: begin
            if (pend_count < QDEPTH) begin
               pend_idx[pend_count] = idx;
               pend_ver[pend_count] = ver;
               pend_count++;
            end else begin
               a.status = vha_pkg::ST_MARK_FULL;
            end
         end
         vha_pkg::CMD_CLEANUP: begin
            for (int k = 0; k < pend_count; k++) begin
               s = int'(pend_idx[k]);
               if (s < slots_used && shadow_live[s] && shadow_ver[s] == pend_ver[k]
                   && free_top < SLOTS) begin
                  shadow_ver[s] = shadow_ver[s] + VW'(1);
                  shadow_live[s] = 0;
                  shadow_free[free_top] = IW'(s);
                  free_top++;
               end
            end
            pend_count = 0;
         end
         default: begin
            if (int'(idx) < slots_used && shadow_live[idx] && shadow_ver[idx] == ver)
               a.valid = 1;
            else
               a.status = vha_pkg::ST_INVALID;
         end
      endcase
      a.alive = OW'(slots_used - free_top);
      a.free = OW'(free_top);
      a.pool = OW'(slots_used);
      return a;
   endfunction

   // offer one word, wait for it to be taken, queue what should come back
   task automatic send(vha_pkg::cmd_type c, logic [IW-1:0] idx, logic [VW-1:0] ver,
                       bit typed, answer_type typed_answer, output answer_type got);
      req_port.valid <= 1'b1;
      req_port.cmd <= c;
      req_port.entity_index <= idx;
      req_port.entity_version <= ver;
      do @(posedge clock); while (!req_port.ready);
      got = allocate_step(c, idx, ver);
      pending_answers = {pending_answers, (typed ? typed_answer : got)};
      words_sent++;
      if (c == vha_pkg::CMD_CREATE && got.status == vha_pkg::ST_OK) begin
         known_handles = {known_handles, {got.index, got.version}};
         if (known_handles.size() > 256) void'(known_handles.pop_front());
      end
      if (got.status == vha_pkg::ST_MARK_FULL) mark_full_seen++;
      if (got.status == vha_pkg::ST_INVALID) invalid_seen++;
      // sender bursts and gaps
      if (burst_left == 0) begin
         req_port.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic issue(vha_pkg::cmd_type c, logic [IW-1:0] idx, logic [VW-1:0] ver);
      answer_type dummy;
      send(c, idx, ver, 0, '0, dummy);
   endtask

   // one random word, mostly built from handles handed out earlier
   task automatic random_word();
      int r;
      logic [25:0] h;
      r = $urandom_range(0, 99);
      h = known_handles.size() > 0 ?
          known_handles[$urandom_range(0, known_handles.size() - 1)] : 26'($urandom);
      if (r < 20) h = 26'($urandom);
      if (r < 35 || known_handles.size() == 0 && r < 50)
         issue(vha_pkg::CMD_CREATE, '0, '0);
      else if (r < 62)
         issue(vha_pkg::CMD_MARK, h[25:16], h[15:0]);
      else if (r < 70)
         issue(vha_pkg::CMD_CLEANUP, IW'($urandom), VW'($urandom));
      else
         issue(vha_pkg::CMD_CHECK, h[25:16], h[15:0]);
   endtask

   task automatic add_row(vha_pkg::cmd_type c, int idx, int ver, bit typed,
                          answer_type a);
      row_type r;
      r.cmd = c;
      r.index = IW'(idx);
      r.version = VW'(ver);
      r.typed = typed;
      r.answer = a;
      script = {script, r};
   endtask

   // receiver stall pattern, with the long hold-off on top
   int stall_window;
   bit stall_busy;
   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_window <= $urandom_range(16, 80);
         stall_busy <= $urandom_range(0, 2) != 0;
      end else begin
         stall_window <= stall_window - 1;
      end
      rsp_port.ready <= !hold_off && (!stall_busy || $urandom_range(0, 9) < 6);
   end

   initial begin
      wait (pressure_go);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   // compare each returned word with the oldest expectation
   always @(posedge clock) begin
      answer_type want, seen;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         seen = {vha_pkg::status_type'(rsp_port.status), rsp_port.out_index,
                 rsp_port.out_version, rsp_port.is_valid, rsp_port.alive_count,
                 rsp_port.free_count, rsp_port.pool_size};
         answers_seen++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", seen);
         end else begin
            want = pending_answers.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: st %0d/%0d idx %0d/%0d ver %0d/%0d vld %0d/%0d",
                            " alive %0d/%0d free %0d/%0d pool %0d/%0d (exp/act)"},
                           want.status, seen.status, want.index, seen.index,
                           want.version, seen.version, want.valid, seen.valid,
                           want.alive, seen.alive, want.free, seen.free,
                           want.pool, seen.pool);
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      answer_type got;
      int n;
      logic [25:0] h;
      req_port.valid = 0;
      req_port.cmd = vha_pkg::CMD_CREATE;
      req_port.entity_index = '0;
      req_port.entity_version = '0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed part: empty pool, first slots, stale, duplicate and foreign marks
      add_row(vha_pkg::CMD_CHECK, 0, 0, 1, '{vha_pkg::ST_INVALID, 0, 0, 0, 0, 0, 0});
      add_row(vha_pkg::CMD_CLEANUP, 0, 0, 1, '{vha_pkg::ST_OK, 0, 0, 0, 0, 0, 0});
      add_row(vha_pkg::CMD_MARK, 5, 7, 1, '{vha_pkg::ST_OK, 0, 0, 0, 0, 0, 0});
      add_row(vha_pkg::CMD_CLEANUP, 0, 0, 1, '{vha_pkg::ST_OK, 0, 0, 0, 0, 0, 0});
      add_row(vha_pkg::CMD_CREATE, 0, 0, 1, '{vha_pkg::ST_OK, 0, 0, 0, 1, 0, 1});
      add_row(vha_pkg::CMD_CREATE, 1023, 16'hffff, 1,
              '{vha_pkg::ST_OK, 1, 0, 0, 2, 0, 2});
      add_row(vha_pkg::CMD_CHECK, 0, 0, 1, '{vha_pkg::ST_OK, 0, 0, 1, 2, 0, 2});
      add_row(vha_pkg::CMD_CHECK, 1023, 16'hffff, 1,
              '{vha_pkg::ST_INVALID, 0, 0, 0, 2, 0, 2});
      add_row(vha_pkg::CMD_CHECK, 0, 16'h8000, 1,
              '{vha_pkg::ST_INVALID, 0, 0, 0, 2, 0, 2});
      add_row(vha_pkg::CMD_MARK, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_MARK, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_MARK, 1023, 16'hffff, 0, '0);
      add_row(vha_pkg::CMD_MARK, 1, 16'h5555, 0, '0);
      add_row(vha_pkg::CMD_CLEANUP, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_CHECK, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_CHECK, 0, 1, 0, '0);
      add_row(vha_pkg::CMD_CREATE, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_CHECK, 0, 1, 0, '0);
      add_row(vha_pkg::CMD_MARK, 1, 0, 0, '0);
      add_row(vha_pkg::CMD_MARK, 0, 1, 0, '0);
      add_row(vha_pkg::CMD_CLEANUP, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_CREATE, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_CREATE, 0, 0, 0, '0);
      add_row(vha_pkg::CMD_CHECK, 2, 0, 0, '0);
      foreach (script[i])
         send(script[i].cmd, script[i].index, script[i].version,
              script[i].typed, script[i].answer, got);

      // random mix of well-formed and stray commands
      repeat (400) random_word();

      // fill the mark queue past its depth
      repeat (QDEPTH + 4) begin
         h = known_handles[$urandom_range(0, known_handles.size() - 1)];
         issue(vha_pkg::CMD_MARK, h[25:16], h[15:0]);
      end
      issue(vha_pkg::CMD_CLEANUP, '0, '0);

      // long receiver hold-off while words keep coming
      pressure_go = 1;
      repeat (60) random_word();

      repeat (100) random_word();
      n = 0;
      while (n < 40) begin
         random_word();
         n++;
      end
      req_port.valid <= 1'b0;

      wait (pending_answers.size() == 0);
      repeat (SETTLE) @(posedge clock);
      $display("run: %0d words sent, %0d answers checked, %0d mark-full, %0d invalid",
               words_sent, answers_seen, mark_full_seen, invalid_seen);
      $display("run: %0d mismatches, %0d answers still owed", mismatches,
               pending_answers.size());
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
